>>> sv/bqe_pkg.sv
package bqe_pkg;

    localparam int INDEX_BITS_DEF = 24;
    localparam int ANGLE_BITS_DEF = 16;

    // right vector falls back to the x axis below this squared length (Q4.28)
    localparam logic [31:0] LEN_MIN_SQ = 32'd269;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    localparam int SQRT_STEPS = 30;
    localparam int DIV_STEPS = 15;
    localparam logic [59:0] SQRT_BIT_INIT = 60'(1) << 58;

    // datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP      = 4'd0;
    localparam op_t OP_LOAD     = 4'd1;
    localparam op_t OP_SUMSQ    = 4'd2;
    localparam op_t OP_SQRT     = 4'd3;
    localparam op_t OP_DIV_INIT = 4'd4;
    localparam op_t OP_DIV_STEP = 4'd5;
    localparam op_t OP_DIV_END  = 4'd6;
    localparam op_t OP_UNIT     = 4'd7;
    localparam op_t OP_UP       = 4'd8;
    localparam op_t OP_SINE     = 4'd9;
    localparam op_t OP_TURN     = 4'd10;
    localparam op_t OP_VMUL     = 4'd11;
    localparam op_t OP_VACC     = 4'd12;
    localparam op_t OP_OUT      = 4'd13;

    // polynomial sequence steps of the quarter-wave sine
    localparam logic [3:0] SIN_SQ      = 4'd0;
    localparam logic [3:0] SIN_SEED    = 4'd1;
    localparam logic [3:0] SIN_FIN_MUL = 4'd10;
    localparam logic [3:0] SIN_LAST    = 4'd11;

    // corner codes
    localparam logic [1:0] CORNER_LL = 2'd0;
    localparam logic [1:0] CORNER_LR = 2'd1;
    localparam logic [1:0] CORNER_UR = 2'd2;
    localparam logic [1:0] CORNER_UL = 2'd3;

    typedef struct packed {
        op_t        op;
        logic [3:0] idx;
        logic       sel;
        logic [1:0] corner;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic tiny_len;
    } stat_t;

    function automatic logic signed [32:0] sin_coef(input logic [2:0] k);
        logic signed [32:0] c;
        case (k)
            3'd0:    c = 33'sd172272;
            3'd1:    c = -33'sd5026995;
            3'd2:    c = 33'sd85569306;
            3'd3:    c = -33'sd693598668;
            default: c = 33'sd1686629713;
        endcase
        return c;
    endfunction

    // shift right by n, rounding half away from zero
    function automatic logic signed [65:0] rnd_sh(input logic signed [65:0] v,
                                                  input int unsigned n);
        logic [65:0] m;
        logic [65:0] h;
        h = 66'(1) << (n - 1);
        m = v[65] ? 66'(-v) : 66'(v);
        m = (m + h) >> n;
        return v[65] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647) r = 32'h7FFF_FFFF;
        else if (v < -66'sd2147483648) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [65:0] v);
        logic [15:0] r;
        if (v > 66'sd32767) r = 16'h7FFF;
        else if (v < -66'sd32768) r = 16'h8000;
        else r = v[15:0];
        return r;
    endfunction

endpackage

>>> sv/bqe_ctrl.sv
module bqe_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_skip_leaf,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  bqe_pkg::stat_t stat,
    output bqe_pkg::cmd_t  cmd
);
    import bqe_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUMSQ = 4'd1;
    localparam logic [3:0] S_SQRT  = 4'd2;
    localparam logic [3:0] S_DIVI  = 4'd3;
    localparam logic [3:0] S_DIVS  = 4'd4;
    localparam logic [3:0] S_DIVE  = 4'd5;
    localparam logic [3:0] S_UP    = 4'd6;
    localparam logic [3:0] S_SINE  = 4'd7;
    localparam logic [3:0] S_TURN  = 4'd8;
    localparam logic [3:0] S_VMUL  = 4'd9;
    localparam logic [3:0] S_VACC  = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       sel_reg, sel_next;
    logic [1:0] corner_reg, corner_next;
    logic       dbl_reg, dbl_next;
    logic       leaf_dbl_reg, leaf_dbl_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;
    logic       last_v;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign last_v = (corner_reg == CORNER_UL) && (sel_reg || !leaf_dbl_reg);

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        sel_next = sel_reg;
        corner_next = corner_reg;
        leaf_dbl_next = leaf_dbl_reg;
        dbl_next = cfg_wr_en ? cfg_wr_data : dbl_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd = '{op: OP_NOP, idx: cnt_reg[3:0], sel: sel_reg, corner: corner_reg, last: last_v};
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                    leaf_dbl_next = dbl_reg;
                    cnt_next = '0;
                    sel_next = 1'b0;
                    if (!s_skip_leaf) state_next = S_SUMSQ;
                end
            end
            S_SUMSQ: begin
                cmd.op = OP_SUMSQ;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.op = OP_SQRT;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQRT_STEPS - 1)) begin
                    cnt_next = '0;
                    state_next = S_DIVI;
                end
            end
            S_DIVI: begin
                cnt_next = '0;
                if (stat.tiny_len) begin
                    cmd.op = OP_UNIT;
                    state_next = S_UP;
                end else begin
                    cmd.op = OP_DIV_INIT;
                    state_next = S_DIVS;
                end
            end
            S_DIVS: begin
                cmd.op = OP_DIV_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) state_next = S_DIVE;
            end
            S_DIVE: begin
                cmd.op = OP_DIV_END;
                cnt_next = '0;
                sel_next = !sel_reg;
                state_next = sel_reg ? S_UP : S_DIVI;
            end
            S_UP: begin
                cmd.op = OP_UP;
                cnt_next = '0;
                sel_next = 1'b0;
                state_next = S_SINE;
            end
            S_SINE: begin
                cmd.op = OP_SINE;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[3:0] == SIN_LAST) begin
                    cnt_next = '0;
                    sel_next = !sel_reg;
                    if (sel_reg) state_next = S_TURN;
                end
            end
            S_TURN: begin
                cmd.op = OP_TURN;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd2) begin
                    cnt_next = '0;
                    sel_next = 1'b0;
                    corner_next = CORNER_LL;
                    state_next = S_VMUL;
                end
            end
            S_VMUL: begin
                cmd.op = OP_VMUL;
                state_next = S_VACC;
            end
            S_VACC: begin
                cmd.op = OP_VACC;
                if (cnt_reg == 5'd2) begin
                    state_next = S_EMIT;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                    state_next = S_VMUL;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.op = OP_OUT;
                    m_valid_next = 1'b1;
                    cnt_next = '0;
                    corner_next = corner_reg + 2'd1;
                    state_next = S_VMUL;
                    if (corner_reg == CORNER_UL) begin
                        if (!sel_reg && leaf_dbl_reg) sel_next = 1'b1;
                        else state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            sel_reg <= 1'b0;
            corner_reg <= CORNER_LL;
            dbl_reg <= 1'b0;
            leaf_dbl_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
            corner_reg <= corner_next;
            dbl_reg <= dbl_next;
            leaf_dbl_reg <= leaf_dbl_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> sv/bqe_dpath.sv
module bqe_dpath #(
    parameter int INDEX_BITS = bqe_pkg::INDEX_BITS_DEF,
    parameter int ANGLE_BITS = bqe_pkg::ANGLE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bqe_pkg::cmd_t       cmd,
    output bqe_pkg::stat_t      stat,
    input  logic signed [31:0]  leaf_x,
    input  logic signed [31:0]  leaf_y,
    input  logic signed [31:0]  leaf_z,
    input  logic signed [15:0]  leaf_nx,
    input  logic signed [15:0]  leaf_ny,
    input  logic signed [15:0]  leaf_nz,
    input  logic [31:0]         leaf_size,
    input  logic [15:0]         turn_angle,
    input  logic                first_leaf,
    output logic signed [31:0]  vert_x,
    output logic signed [31:0]  vert_y,
    output logic signed [31:0]  vert_z,
    output logic signed [15:0]  norm_x,
    output logic signed [15:0]  norm_y,
    output logic signed [15:0]  norm_z,
    output logic signed [15:0]  tan_x,
    output logic signed [15:0]  tan_y,
    output logic signed [15:0]  tan_z,
    output logic [1:0]          corner,
    output logic [23:0]         vertex_index,
    output logic                last_vertex
);
    import bqe_pkg::*;

    logic signed [31:0] pos_reg [3];
    logic signed [15:0] n_reg [3];
    logic [31:0]        size_reg;
    logic [ANGLE_BITS-1:0] ang_reg;
    logic               tiny_reg;
    logic [59:0]        rem_reg, root_reg, bit_reg;
    logic [43:0]        num_reg, den_reg;
    logic [14:0]        quo_reg;
    logic               dneg_reg;
    logic signed [15:0] r0_reg, r2_reg;
    logic signed [17:0] u_reg [3];
    logic signed [32:0] x2_reg, p_reg;
    logic signed [15:0] sf_reg, cf_reg;
    logic signed [18:0] rr_reg [3], ru_reg [3];
    logic signed [65:0] prod_reg;
    logic [31:0]        vst_reg [3];
    logic [15:0]        nst_reg [3], tst_reg [3];
    logic [INDEX_BITS-1:0] count_reg;
    logic [31:0]        ox_reg, oy_reg, oz_reg;
    logic [15:0]        onx_reg, ony_reg, onz_reg, otx_reg, oty_reg, otz_reg;
    logic [1:0]         ocorner_reg;
    logic [23:0]        oidx_reg;
    logic               olast_reg;

    logic [1:0]         comp;
    logic signed [31:0] sq_x, sq_z;
    logic [31:0]        s_sum;
    logic [60:0]        sq_try;
    logic               sq_ge;
    logic [29:0]        len;
    logic signed [15:0] dv_a;
    logic [15:0]        dv_mag;
    logic               dv_neg;
    logic               div_ge;
    logic signed [15:0] r_q;
    logic signed [31:0] up_a, up_b, up_c, up_d;
    logic [19:0]        phase;
    logic [18:0]        arg;
    logic signed [32:0] x_val;
    logic signed [65:0] fin;
    logic signed [15:0] sres;
    logic signed [15:0] sv, cv, r_sel;
    logic signed [17:0] u_sel;
    logic signed [31:0] p_rc, p_rs;
    logic signed [33:0] p_uc, p_us;
    logic signed [34:0] t_rr, t_ru;
    logic signed [18:0] a_val, ru_val;
    logic signed [20:0] v_val;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] vsum;

    assign comp = cmd.idx[1:0];
    assign stat.tiny_len = tiny_reg;

    always_comb begin
        // squared length of the normal in the xz plane
        sq_x = n_reg[0] * n_reg[0];
        sq_z = n_reg[2] * n_reg[2];
        s_sum = $unsigned(sq_x) + $unsigned(sq_z);

        sq_try = {1'b0, root_reg} + {1'b0, bit_reg};
        sq_ge = {1'b0, rem_reg} >= sq_try;

        len = root_reg[29:0];
        dv_a = cmd.sel ? n_reg[0] : n_reg[2];
        dv_mag = dv_a[15] ? 16'(-dv_a) : 16'(dv_a);
        dv_neg = cmd.sel ? (!n_reg[0][15] && n_reg[0] != 16'sd0) : n_reg[2][15];
        div_ge = num_reg >= den_reg;
        r_q = dneg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

        up_a = n_reg[1] * r2_reg;
        up_b = n_reg[1] * r0_reg;
        up_c = n_reg[2] * r0_reg;
        up_d = n_reg[0] * r2_reg;

        phase = 20'(ang_reg) << (20 - ANGLE_BITS);
        arg = cmd.sel ? (19'h40000 - {1'b0, phase[17:0]}) : {1'b0, phase[17:0]};
        x_val = $signed({2'b00, arg, 12'd0});
        fin = rnd_sh(rnd_sh(prod_reg, 30), 16);
        if (fin < 66'sd0) sres = 16'sd0;
        else if (fin > 66'sd16384) sres = ONE_Q14;
        else sres = fin[15:0];

        case (phase[19:18])
            2'd0: begin sv = sf_reg;  cv = cf_reg;  end
            2'd1: begin sv = cf_reg;  cv = -sf_reg; end
            2'd2: begin sv = -sf_reg; cv = -cf_reg; end
            default: begin sv = -cf_reg; cv = sf_reg; end
        endcase
        if (comp == 2'd0) r_sel = r0_reg;
        else if (comp == 2'd2) r_sel = r2_reg;
        else r_sel = 16'sd0;
        u_sel = u_reg[comp];
        p_rc = r_sel * cv;
        p_rs = r_sel * sv;
        p_uc = u_sel * cv;
        p_us = u_sel * sv;
        t_rr = 35'(p_rc) + 35'(p_us);
        t_ru = 35'(p_uc) - 35'(p_rs);

        // corner offset: right and up with the corner's signs
        a_val = cmd.sel ? 19'(n_reg[comp]) : rr_reg[comp];
        ru_val = ru_reg[comp];
        v_val = ((cmd.corner == CORNER_LL || cmd.corner == CORNER_UL) ? -21'(a_val) : 21'(a_val))
              + ((cmd.corner == CORNER_LL || cmd.corner == CORNER_LR) ? -21'(ru_val)
                                                                      : 21'(ru_val));

        mul_a = p_reg;
        mul_b = x2_reg;
        if (cmd.op == OP_VMUL) begin
            mul_a = 33'(v_val);
            mul_b = $signed({1'b0, size_reg});
        end else if (cmd.idx == SIN_SQ) begin
            mul_a = x_val;
            mul_b = x_val;
        end else if (cmd.idx == SIN_FIN_MUL) begin
            mul_a = x_val;
            mul_b = p_reg;
        end
        mul_p = mul_a * mul_b;

        vsum = 66'(pos_reg[comp]) + rnd_sh(prod_reg, 15);
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_NOP: ;
            OP_LOAD: begin
                pos_reg[0] <= leaf_x;
                pos_reg[1] <= leaf_y;
                pos_reg[2] <= leaf_z;
                n_reg[0] <= leaf_nx;
                n_reg[1] <= leaf_ny;
                n_reg[2] <= leaf_nz;
                size_reg <= leaf_size;
                ang_reg <= ANGLE_BITS'(turn_angle);
            end
            OP_SUMSQ: begin
                tiny_reg <= s_sum < LEN_MIN_SQ;
                rem_reg <= {s_sum, 28'd0};
                root_reg <= '0;
                bit_reg <= SQRT_BIT_INIT;
            end
            OP_SQRT: begin
                if (sq_ge) begin
                    rem_reg <= rem_reg - sq_try[59:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_DIV_INIT: begin
                num_reg <= {dv_mag, 28'd0} + 44'(len >> 1);
                den_reg <= {len, 14'd0};
                quo_reg <= '0;
                dneg_reg <= dv_neg;
            end
            OP_DIV_STEP: begin
                if (div_ge) begin
                    num_reg <= num_reg - den_reg;
                    quo_reg <= {quo_reg[13:0], 1'b1};
                end else begin
                    quo_reg <= {quo_reg[13:0], 1'b0};
                end
                den_reg <= den_reg >> 1;
            end
            OP_DIV_END: begin
                if (cmd.sel) r2_reg <= r_q;
                else r0_reg <= r_q;
            end
            OP_UNIT: begin
                r0_reg <= ONE_Q14;
                r2_reg <= 16'sd0;
            end
            OP_UP: begin
                u_reg[0] <= 18'(rnd_sh(66'(up_a), 14));
                u_reg[1] <= 18'(rnd_sh(66'(up_c) - 66'(up_d), 14));
                u_reg[2] <= 18'(rnd_sh(-66'(up_b), 14));
            end
            OP_SINE: begin
                if (!cmd.idx[0]) begin
                    prod_reg <= mul_p;
                end else if (cmd.idx == SIN_SEED) begin
                    x2_reg <= 33'(rnd_sh(prod_reg, 30));
                    p_reg <= sin_coef(3'd0);
                end else if (cmd.idx == SIN_LAST) begin
                    if (cmd.sel) cf_reg <= sres;
                    else sf_reg <= sres;
                end else begin
                    p_reg <= sin_coef(cmd.idx[3:1]) + 33'(rnd_sh(prod_reg, 30));
                end
            end
            OP_TURN: begin
                rr_reg[comp] <= 19'(rnd_sh(66'(t_rr), 14));
                ru_reg[comp] <= 19'(rnd_sh(66'(t_ru), 14));
            end
            OP_VMUL: prod_reg <= mul_p;
            OP_VACC: begin
                vst_reg[comp] <= sat32(vsum);
                nst_reg[comp] <= cmd.sel ? sat16(-66'(rr_reg[comp])) : n_reg[comp];
                tst_reg[comp] <= sat16(66'(a_val));
            end
            OP_OUT: begin
                ox_reg <= vst_reg[0];
                oy_reg <= vst_reg[1];
                oz_reg <= vst_reg[2];
                onx_reg <= nst_reg[0];
                ony_reg <= nst_reg[1];
                onz_reg <= nst_reg[2];
                otx_reg <= tst_reg[0];
                oty_reg <= tst_reg[1];
                otz_reg <= tst_reg[2];
                ocorner_reg <= cmd.corner;
                oidx_reg <= 24'(count_reg);
                olast_reg <= cmd.last;
            end
            default: ;
        endcase
    end

    // running vertex number
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.op == OP_LOAD && first_leaf) begin
            count_reg <= '0;
        end else if (cmd.op == OP_OUT) begin
            count_reg <= count_reg + INDEX_BITS'(1);
        end
    end

    assign vert_x = ox_reg;
    assign vert_y = oy_reg;
    assign vert_z = oz_reg;
    assign norm_x = onx_reg;
    assign norm_y = ony_reg;
    assign norm_z = onz_reg;
    assign tan_x = otx_reg;
    assign tan_y = oty_reg;
    assign tan_z = otz_reg;
    assign corner = ocorner_reg;
    assign vertex_index = oidx_reg;
    assign last_vertex = olast_reg;

endmodule

>>> sv/billboard_quad_expander.sv
// channel   direction  handshake          beat
// s_*       in         s_valid/s_ready    one leaf: centre, normal, size, angle, flags
// m_*       out        m_valid/m_ready    one vertex: position, normal, tangent, index
// cfg_*     in         cfg_wr_en          double_billboard bit, no wait
//
// a skipped leaf produces no vertices; any other leaf runs a setup of
// 30 square root steps, two divides and the sine polynomial for sine and cosine on the
// shared 33x33 multiplier, with no divide when the normal is nearly vertical,
// and then gives 4 or 8 vertices per leaf
// reset is synchronous, active low, and clears the control state, the vertex
// count and the double_billboard bit
// a stalled m_ready holds the vertex in the output register while the next
// vertex is computed; the block waits there until the beat is taken
module billboard_quad_expander #(
    parameter int INDEX_BITS = bqe_pkg::INDEX_BITS_DEF,
    parameter int ANGLE_BITS = bqe_pkg::ANGLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_leaf_x,
    input  logic signed [31:0] s_leaf_y,
    input  logic signed [31:0] s_leaf_z,
    input  logic signed [15:0] s_leaf_nx,
    input  logic signed [15:0] s_leaf_ny,
    input  logic signed [15:0] s_leaf_nz,
    input  logic [31:0]        s_leaf_size,
    input  logic [15:0]        s_turn_angle,
    input  logic               s_skip_leaf,
    input  logic               s_first_leaf,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_vert_x,
    output logic signed [31:0] m_vert_y,
    output logic signed [31:0] m_vert_z,
    output logic signed [15:0] m_norm_x,
    output logic signed [15:0] m_norm_y,
    output logic signed [15:0] m_norm_z,
    output logic signed [15:0] m_tan_x,
    output logic signed [15:0] m_tan_y,
    output logic signed [15:0] m_tan_z,
    output logic [1:0]         m_corner,
    output logic [23:0]        m_vertex_index,
    output logic               m_last_vertex
);
    import bqe_pkg::*;

    cmd_t  cmd;   // controller to datapath, one operation per cycle
    stat_t stat;  // short normal flag back to the controller

    // sequencer: leaf intake, iteration counters, corner loop, output valid
    bqe_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_skip_leaf (s_skip_leaf),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat),
        .cmd         (cmd)
    );

    // arithmetic: sqrt, divider, sine polynomial, rotation, corner offsets
    bqe_dpath #(
        .INDEX_BITS (INDEX_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .leaf_x       (s_leaf_x),
        .leaf_y       (s_leaf_y),
        .leaf_z       (s_leaf_z),
        .leaf_nx      (s_leaf_nx),
        .leaf_ny      (s_leaf_ny),
        .leaf_nz      (s_leaf_nz),
        .leaf_size    (s_leaf_size),
        .turn_angle   (s_turn_angle),
        .first_leaf   (s_first_leaf),
        .vert_x       (m_vert_x),
        .vert_y       (m_vert_y),
        .vert_z       (m_vert_z),
        .norm_x       (m_norm_x),
        .norm_y       (m_norm_y),
        .norm_z       (m_norm_z),
        .tan_x        (m_tan_x),
        .tan_y        (m_tan_y),
        .tan_z        (m_tan_z),
        .corner       (m_corner),
        .vertex_index (m_vertex_index),
        .last_vertex  (m_last_vertex)
    );

endmodule

>>> sv/bqe_checker.sv
module bqe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_skip_leaf,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_corner,
    input logic [23:0] m_vertex_index,
    input logic        m_last_vertex
);
    import bqe_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vertex_index))
        else $error("output beat dropped or changed while stalled");

    a_rst_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_skip_leaf |=> !s_ready)
        else $error("new leaf taken while one is in work");

    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_vertex |-> m_corner == CORNER_UL)
        else $error("last vertex flag on a corner other than the final one");

endmodule

bind billboard_quad_expander bqe_checker u_bqe_checker (.*);
